/* rtl/world_to_screen_projection_core_assert.svh */
// assertion macros used by the back of the projection core rtl
`ifndef WORLD_TO_SCREEN_PROJECTION_CORE_ASSERT_SVH
`define WORLD_TO_SCREEN_PROJECTION_CORE_ASSERT_SVH

// property checked every clock outside reset
`define W2S_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define W2S_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

/* rtl/w2s_pkg.sv */
// types, constants and helpers of the projection core
`timescale 1ns / 1ps
`default_nettype none
package w2s_pkg;

  localparam int FRAC_BITS = 16;
  localparam int W_MIN_RAW = ((1 << FRAC_BITS) + 500) / 1000;
  localparam int W_MIN     = (W_MIN_RAW > 0) ? W_MIN_RAW : 1;
  localparam int FAR_SCALE = 100000;
  localparam int FAR_W     = 50;
  localparam int ACC_W     = 66;
  localparam int DIV_STEPS = 32 + FRAC_BITS;
  localparam int MID_DEPTH = 4;
  localparam int MID_AW    = 2;
  localparam int OUT_DEPTH = 64;
  localparam int OUT_AW    = 6;

  typedef enum logic [3:0] {
    REG_ROW0_A   = 4'd0,
    REG_ROW0_B   = 4'd1,
    REG_ROW1_A   = 4'd2,
    REG_ROW1_B   = 4'd3,
    REG_ROWW_A   = 4'd4,
    REG_ROWW_B   = 4'd5,
    REG_SCREEN_W = 4'd6,
    REG_SCREEN_H = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [63:0] row0_a;
    logic [63:0] row0_b;
    logic [63:0] row1_a;
    logic [63:0] row1_b;
    logic [63:0] roww_a;
    logic [63:0] roww_b;
    logic [13:0] width;
    logic [13:0] height;
  } cfg_t;

  typedef struct packed {
    logic              vis;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] w;
  } clip_t;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic               vis;
  } res_t;

  typedef struct packed {
    logic [31:0]          rem;
    logic [DIV_STEPS-1:0] dq;
  } lane_t;

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[ACC_W-1:31];
    hi_zeros = ~|v[ACC_W-1:31];
    if (hi_ones || hi_zeros) return v[31:0];
    else if (v[ACC_W-1]) return 32'sh8000_0000;
    else return 32'sh7fff_ffff;
  endfunction

  // one restoring division step, quotient bits shift into the dividend
  function automatic lane_t div_step(input lane_t l, input logic [31:0] w);
    lane_t       o;
    logic [32:0] t;
    logic        ge;
    t  = {l.rem, l.dq[DIV_STEPS-1]};
    ge = (t >= {1'b0, w});
    o.rem = ge ? 32'(t - {1'b0, w}) : t[31:0];
    o.dq  = {l.dq[DIV_STEPS-2:0], ge};
    return o;
  endfunction

endpackage
`default_nettype wire

/* rtl/world_to_screen_projection_core.sv */
// top level: config registers and front, queue and back of the projection core
//
//  channel  ports                                      beat taken when
//  input    push full in_world_x/y/z                   push && !full
//  result   empty pop out_screen_x/y out_visible       pop && !empty
//  config   cfg_valid cfg_ready cfg_index cfg_data     cfg_valid && cfg_ready
//
// one point per cycle sustained while full stays low; a result reaches the output ports
// through the product and sum stages, middle queue, 48-stage divider, two map
// stages and result memory read, and can be popped once empty falls.
// reset is synchronous, active low; config registers return to defaults.
// full rises when the front and middle queue hold four points; the back stops
// issuing when 64 results are in flight or waiting, then the front backs up.
`timescale 1ns / 1ps
`default_nettype none
module world_to_screen_projection_core (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  output logic               full,
  input  wire signed [31:0]  in_world_x,
  input  wire signed [31:0]  in_world_y,
  input  wire signed [31:0]  in_world_z,
  output logic               empty,
  input  wire                pop,
  output logic signed [31:0] out_screen_x,
  output logic signed [31:0] out_screen_y,
  output logic               out_visible,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire [3:0]          cfg_index,
  input  wire [63:0]         cfg_data
);
  import w2s_pkg::*;

  cfg_t  cfg_r;
  clip_t f_clip;
  logic  f_valid;
  clip_t q_head;
  logic  q_valid;
  logic  b_deq;
  res_t  b_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row0_a <= 64'd65536;
      cfg_r.row0_b <= 64'd0;
      cfg_r.row1_a <= 64'h0001_0000_0000_0000;
      cfg_r.row1_b <= 64'd0;
      cfg_r.roww_a <= 64'd0;
      cfg_r.roww_b <= 64'h0001_0000_0000_0000;
      cfg_r.width  <= 14'd1920;
      cfg_r.height <= 14'd1080;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW0_A:   cfg_r.row0_a <= cfg_data;
        REG_ROW0_B:   cfg_r.row0_b <= cfg_data;
        REG_ROW1_A:   cfg_r.row1_a <= cfg_data;
        REG_ROW1_B:   cfg_r.row1_b <= cfg_data;
        REG_ROWW_A:   cfg_r.roww_a <= cfg_data;
        REG_ROWW_B:   cfg_r.roww_b <= cfg_data;
        REG_SCREEN_W: cfg_r.width  <= cfg_data[13:0];
        REG_SCREEN_H: cfg_r.height <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  w2s_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .push       (push),
    .full       (full),
    .world_x    (in_world_x),
    .world_y    (in_world_y),
    .world_z    (in_world_z),
    .clip       (f_clip),
    .clip_valid (f_valid),
    .deq        (b_deq)
  );

  w2s_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (f_valid),
    .wr_data   (f_clip),
    .rd_en     (b_deq),
    .rd_data   (q_head),
    .not_empty (q_valid)
  );

  w2s_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (q_head),
    .head_valid (q_valid),
    .deq        (b_deq),
    .res        (b_res),
    .empty      (empty),
    .pop        (pop)
  );

  assign out_screen_x = b_res.sx;
  assign out_screen_y = b_res.sy;
  assign out_visible  = b_res.vis;

endmodule
`default_nettype wire

/* rtl/w2s_front.sv */
// front: matrix rows times world point, clip values and visibility class
`timescale 1ns / 1ps
`default_nettype none
module w2s_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  w2s_pkg::cfg_t       cfg,
  input  wire                 push,
  output logic                full,
  input  wire signed [31:0]   world_x,
  input  wire signed [31:0]   world_y,
  input  wire signed [31:0]   world_z,
  output w2s_pkg::clip_t      clip,
  output logic                clip_valid,
  input  wire                 deq
);
  import w2s_pkg::*;

  logic               s1v_r;
  logic signed [63:0] p_r [9];
  logic signed [31:0] off_r [3];
  logic               s2v_r;
  clip_t              clip_r;
  logic [2:0]         fo_r;
  logic [2:0]         fo_nxt;
  logic               acc_in;
  logic signed [ACC_W-1:0] acc_x;
  logic signed [ACC_W-1:0] acc_y;
  logic signed [ACC_W-1:0] acc_w;
  logic signed [31:0] w_sat;

  assign full   = (fo_r == 3'(MID_DEPTH));
  assign acc_in = push && !full;

  // credits cover the pipe and the middle queue
  always_comb begin
    fo_nxt = fo_r;
    if (acc_in && !deq) fo_nxt = fo_r + 3'd1;
    else if (!acc_in && deq) fo_nxt = fo_r - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fo_r  <= '0;
      s1v_r <= 1'b0;
      s2v_r <= 1'b0;
    end else begin
      fo_r  <= fo_nxt;
      s1v_r <= acc_in;
      s2v_r <= s1v_r;
    end
  end

  always_ff @(posedge clk) begin
    p_r[0]   <= $signed(cfg.row0_a[31:0])  * world_x;
    p_r[1]   <= $signed(cfg.row0_a[63:32]) * world_y;
    p_r[2]   <= $signed(cfg.row0_b[31:0])  * world_z;
    p_r[3]   <= $signed(cfg.row1_a[31:0])  * world_x;
    p_r[4]   <= $signed(cfg.row1_a[63:32]) * world_y;
    p_r[5]   <= $signed(cfg.row1_b[31:0])  * world_z;
    p_r[6]   <= $signed(cfg.roww_a[31:0])  * world_x;
    p_r[7]   <= $signed(cfg.roww_a[63:32]) * world_y;
    p_r[8]   <= $signed(cfg.roww_b[31:0])  * world_z;
    off_r[0] <= $signed(cfg.row0_b[63:32]);
    off_r[1] <= $signed(cfg.row1_b[63:32]);
    off_r[2] <= $signed(cfg.roww_b[63:32]);
  end

  // floored products plus offset
  always_comb begin
    acc_x = ACC_W'(off_r[0]) + ACC_W'(p_r[0] >>> FRAC_BITS)
          + ACC_W'(p_r[1] >>> FRAC_BITS) + ACC_W'(p_r[2] >>> FRAC_BITS);
    acc_y = ACC_W'(off_r[1]) + ACC_W'(p_r[3] >>> FRAC_BITS)
          + ACC_W'(p_r[4] >>> FRAC_BITS) + ACC_W'(p_r[5] >>> FRAC_BITS);
    acc_w = ACC_W'(off_r[2]) + ACC_W'(p_r[6] >>> FRAC_BITS)
          + ACC_W'(p_r[7] >>> FRAC_BITS) + ACC_W'(p_r[8] >>> FRAC_BITS);
    w_sat = sat32(acc_w);
  end

  always_ff @(posedge clk) begin
    clip_r.cx  <= sat32(acc_x);
    clip_r.cy  <= sat32(acc_y);
    clip_r.w   <= w_sat;
    clip_r.vis <= (w_sat >= 32'(W_MIN));
  end

  assign clip       = clip_r;
  assign clip_valid = s2v_r;

endmodule
`default_nettype wire

/* rtl/w2s_queue.sv */
// small queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module w2s_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 wr_en,
  input  w2s_pkg::clip_t      wr_data,
  input  wire                 rd_en,
  output w2s_pkg::clip_t      rd_data,
  output logic                not_empty
);
  import w2s_pkg::*;

  clip_t             q_r [MID_DEPTH];
  logic [MID_AW-1:0] wp_r;
  logic [MID_AW-1:0] rp_r;
  logic [MID_AW:0]   cnt_r;
  logic [MID_AW:0]   cnt_nxt;

  assign not_empty = (cnt_r != '0);
  assign rd_data   = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) cnt_nxt = cnt_r + 1'b1;
    else if (!wr_en && rd_en) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) q_r[wp_r] <= wr_data;
  end

endmodule
`default_nettype wire

/* rtl/w2s_back.sv */
// back: perspective divide, viewport map, far scaling and result queue
`timescale 1ns / 1ps
`default_nettype none
module w2s_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  w2s_pkg::cfg_t       cfg,
  input  w2s_pkg::clip_t      head,
  input  wire                 head_valid,
  output logic                deq,
  output w2s_pkg::res_t       res,
  output logic                empty,
  input  wire                 pop
);
  import w2s_pkg::*;
  `include "world_to_screen_projection_core_assert.svh"

  typedef struct packed {
    logic                   vis;
    logic                   negx;
    logic                   negy;
    logic [31:0]            w;
    logic signed [FAR_W-1:0] farx;
    logic signed [FAR_W-1:0] fary;
    lane_t                  lx;
    lane_t                  ly;
  } dstage_t;

  dstage_t            d_r  [DIV_STEPS+1];
  dstage_t            dn_nxt [DIV_STEPS];
  logic               dv_r [DIV_STEPS+1];
  dstage_t            ld;
  logic [32:0]        magx;
  logic [32:0]        magy;

  logic               p1v_r;
  logic               p1vis_r;
  logic signed [31:0] nx_r;
  logic signed [31:0] ny_r;
  logic signed [FAR_W-1:0] farx_r;
  logic signed [FAR_W-1:0] fary_r;
  logic signed [ACC_W-1:0] qx;
  logic signed [ACC_W-1:0] qy;

  logic               p2v_r;
  logic               p2vis_r;
  logic signed [46:0] mx_r;
  logic signed [46:0] my_r;
  logic signed [31:0] fx_r;
  logic signed [31:0] fy_r;
  res_t               wres;

  res_t               mem [OUT_DEPTH];
  logic [OUT_AW-1:0]  wp_r;
  logic [OUT_AW-1:0]  rp_r;
  logic [OUT_AW:0]    mem_cnt_r;
  logic               hv_r;
  res_t               out_r;
  logic               mem_rd;
  logic               pop_ok;
  logic [OUT_AW:0]    oc_r;

  assign pop_ok = pop && hv_r;
  assign deq    = head_valid && (oc_r < (OUT_AW+1)'(OUT_DEPTH));
  assign mem_rd = (mem_cnt_r != '0) && (!hv_r || pop_ok);
  assign empty  = !hv_r;
  assign res    = out_r;

  // load magnitudes and far products into the divider
  always_comb begin
    magx    = head.cx[31] ? (33'd0 - {head.cx[31], head.cx}) : {head.cx[31], head.cx};
    magy    = head.cy[31] ? (33'd0 - {head.cy[31], head.cy}) : {head.cy[31], head.cy};
    ld.vis  = head.vis;
    ld.negx = head.cx[31];
    ld.negy = head.cy[31];
    ld.w    = head.w;
    ld.farx = FAR_W'(head.cx) * FAR_W'(FAR_SCALE);
    ld.fary = FAR_W'(head.cy) * FAR_W'(FAR_SCALE);
    ld.lx.rem = '0;
    ld.lx.dq  = {magx[31:0], {FRAC_BITS{1'b0}}};
    ld.ly.rem = '0;
    ld.ly.dq  = {magy[31:0], {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DIV_STEPS; i++) dv_r[i] <= 1'b0;
      p1v_r <= 1'b0;
      p2v_r <= 1'b0;
    end else begin
      dv_r[0] <= deq;
      for (int i = 0; i < DIV_STEPS; i++) dv_r[i+1] <= dv_r[i];
      p1v_r <= dv_r[DIV_STEPS];
      p2v_r <= p1v_r;
    end
  end

  // one quotient bit per stage for each lane
  always_comb begin
    for (int i = 0; i < DIV_STEPS; i++) begin
      dn_nxt[i]    = d_r[i];
      dn_nxt[i].lx = div_step(d_r[i].lx, d_r[i].w);
      dn_nxt[i].ly = div_step(d_r[i].ly, d_r[i].w);
    end
  end

  always_ff @(posedge clk) begin
    d_r[0] <= ld;
    for (int i = 0; i < DIV_STEPS; i++) d_r[i+1] <= dn_nxt[i];
  end

  always_comb begin
    qx = ACC_W'({1'b0, d_r[DIV_STEPS].lx.dq});
    qy = ACC_W'({1'b0, d_r[DIV_STEPS].ly.dq});
    if (d_r[DIV_STEPS].negx) qx = -qx;
    if (d_r[DIV_STEPS].negy) qy = -qy;
  end

  always_ff @(posedge clk) begin
    p1vis_r <= d_r[DIV_STEPS].vis;
    nx_r    <= sat32(qx);
    ny_r    <= sat32(qy);
    farx_r  <= d_r[DIV_STEPS].farx;
    fary_r  <= d_r[DIV_STEPS].fary;
  end

  always_ff @(posedge clk) begin
    p2vis_r <= p1vis_r;
    mx_r    <= 47'($signed({1'b0, cfg.width}))  * 47'(nx_r);
    my_r    <= 47'($signed({1'b0, cfg.height})) * 47'(ny_r);
    fx_r    <= sat32(ACC_W'(farx_r));
    fy_r    <= sat32(ACC_W'(fary_r));
  end

  // viewport center plus or minus half the scaled ndc
  always_comb begin
    wres.vis = p2vis_r;
    if (p2vis_r) begin
      wres.sx = sat32((ACC_W'({1'b0, cfg.width})  << (FRAC_BITS-1)) + ACC_W'(mx_r >>> 1));
      wres.sy = sat32((ACC_W'({1'b0, cfg.height}) << (FRAC_BITS-1)) - ACC_W'(my_r >>> 1));
    end else begin
      wres.sx = fx_r;
      wres.sy = fy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p2v_r) mem[wp_r] <= wres;
    if (mem_rd) out_r <= mem[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      rp_r      <= '0;
      mem_cnt_r <= '0;
      hv_r      <= 1'b0;
      oc_r      <= '0;
    end else begin
      if (p2v_r) wp_r <= wp_r + 1'b1;
      if (mem_rd) rp_r <= rp_r + 1'b1;
      if (p2v_r && !mem_rd) mem_cnt_r <= mem_cnt_r + 1'b1;
      else if (!p2v_r && mem_rd) mem_cnt_r <= mem_cnt_r - 1'b1;
      if (mem_rd) hv_r <= 1'b1;
      else if (pop_ok) hv_r <= 1'b0;
      if (deq && !pop_ok) oc_r <= oc_r + 1'b1;
      else if (!deq && pop_ok) oc_r <= oc_r - 1'b1;
    end
  end

  `W2S_ASSERT(a_credit_bound, oc_r <= (OUT_AW+1)'(OUT_DEPTH), "result credits overrun")
  `W2S_ASSERT(a_held_in_credit, (mem_cnt_r + {{OUT_AW{1'b0}}, hv_r}) <= oc_r, "beats exceed credits")
  `W2S_ASSERT_NEXT(a_pop_returns, pop_ok && !deq, oc_r == $past(oc_r) - 1'b1, "credit not returned")

endmodule
`default_nettype wire
